// File: rtl/mgd_pkg.sv
// Shared types and constants for the masked grid diffusion unit.
`default_nettype none
package mgd_pkg;

  localparam int VEL_W  = 32;
  localparam int ACC_W  = 36;
  localparam int RATE_W = 16;
  localparam int PROD_W = ACC_W + RATE_W + 1;
  localparam int SUM_W  = VEL_W + 6;
  localparam int FRAC_W = 16;

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_RUN  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_STEPS  = 2'd2;
  localparam logic [1:0] REG_RATE   = 2'd3;

  localparam logic RESP_RUN  = 1'b0;
  localparam logic RESP_READ = 1'b1;

  typedef struct packed {
    logic mul_en;
    logic sel_y;
  } alu_ctl_t;

endpackage
`default_nettype wire

// File: rtl/mgd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mgd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/mgd_alu.sv
// Shared multiply, round and saturate unit for one velocity lane at a time.
`default_nettype none
module mgd_alu (
  input  wire logic                             clk,
  input  wire mgd_pkg::alu_ctl_t                ctl,
  input  wire logic [mgd_pkg::RATE_W-1:0]       rate,
  input  wire mgd_pkg::acc_t                    acc_x,
  input  wire mgd_pkg::acc_t                    acc_y,
  input  wire mgd_pkg::vel_t                    cen_x,
  input  wire mgd_pkg::vel_t                    cen_y,
  output mgd_pkg::vel_t                         result
);

  logic signed [mgd_pkg::PROD_W-1:0] prod;
  mgd_pkg::vel_t                     cen;
  logic signed [mgd_pkg::PROD_W-1:0] rnd;
  logic signed [mgd_pkg::SUM_W-1:0]  sum;
  mgd_pkg::acc_t                     acc_sel;

  assign acc_sel = ctl.sel_y ? acc_y : acc_x;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= $signed({1'b0, rate}) * acc_sel;
      cen  <= ctl.sel_y ? cen_y : cen_x;
    end
  end

  // Round to nearest with ties toward plus infinity, then saturate.
  assign rnd = (prod + (mgd_pkg::PROD_W)'(signed'(33'sd32768))) >>> mgd_pkg::FRAC_W;
  assign sum = (mgd_pkg::SUM_W)'(cen) + $signed(rnd[mgd_pkg::SUM_W-1:0]);

  always_comb begin
    if (sum > (mgd_pkg::SUM_W)'(signed'(33'sh07FFFFFFF))) begin
      result = 32'sh7FFFFFFF;
    end else if (sum < -(mgd_pkg::SUM_W)'(signed'(34'sh080000000))) begin
      result = 32'sh80000000;
    end else begin
      result = sum[mgd_pkg::VEL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: rtl/masked_grid_diffusion_unit.sv
// Top level: request sequencer, ping-pong field stores and active mask.
//
//  channel   signals                                       handshake
//  request   req_type cell_index load_vel_x/y load_active  start high, busy low
//  result    resp_kind out_vel_x out_vel_y                 done, one cycle
//  config    cfg_index cfg_data                            cfg_we, no wait
//
// A load is written in the cycle of start and leaves busy low. A read answers from ST_RDOUT.
// A run first steps through ST_Z0 and ST_Z1 per cell to zero the inactive cells of the
// current store, then through ST_R0 to ST_R5, ST_MX, ST_MY and ST_WR per cell per step
// (five reads of the one store read port, two passes of the shared multiplier, write back),
// and answers from ST_DONE, straight away if steps, rate or grid size is zero.
// Reset is synchronous; the stores are not cleared. The receiver cannot stall.
`default_nettype none
module masked_grid_diffusion_unit #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  req_type,
  input  wire logic [11:0] cell_index,
  input  wire logic [31:0] load_vel_x,
  input  wire logic [31:0] load_vel_y,
  input  wire logic        load_active,
  output logic             done,
  output logic             resp_kind,
  output logic [31:0]      out_vel_x,
  output logic [31:0]      out_vel_y,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RDOUT = 4'd1;
  localparam logic [3:0] ST_DONE  = 4'd2;
  localparam logic [3:0] ST_R0    = 4'd3;
  localparam logic [3:0] ST_R1    = 4'd4;
  localparam logic [3:0] ST_R2    = 4'd5;
  localparam logic [3:0] ST_R3    = 4'd6;
  localparam logic [3:0] ST_R4    = 4'd7;
  localparam logic [3:0] ST_R5    = 4'd8;
  localparam logic [3:0] ST_MX    = 4'd9;
  localparam logic [3:0] ST_MY    = 4'd10;
  localparam logic [3:0] ST_WR    = 4'd11;
  localparam logic [3:0] ST_Z0    = 4'd12;
  localparam logic [3:0] ST_Z1    = 4'd13;

  logic [6:0]  grid_width;
  logic [6:0]  grid_height;
  logic [15:0] step_count;
  logic [15:0] diffusion_rate;

  logic [3:0]  state;
  logic        cur;
  logic [6:0]  pos_x;
  logic [6:0]  pos_y;
  logic [AW-1:0] pos_c;
  logic [15:0] steps_left;
  logic        in_range;

  mgd_pkg::acc_t acc_x;
  mgd_pkg::acc_t acc_y;
  mgd_pkg::vel_t cen_x;
  mgd_pkg::vel_t cen_y;
  mgd_pkg::vel_t res_x;
  logic          cen_act;

  logic [6:0]   eff_w;
  logic [6:0]   eff_h;
  logic [13:0]  cell_total;
  logic         idx_ok;
  logic [AW+11:0] idx_wide;
  logic [AW-1:0]  idx_addr;
  logic [AW-1:0]  w_a;

  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [63:0]   wdata;
  logic          wr_run;
  logic          wr_load;
  logic          wr_zero;
  logic          we_a;
  logic          we_b;
  logic [63:0]   rdata_a;
  logic [63:0]   rdata_b;
  logic [63:0]   rdata;
  logic          mask_rd;
  logic [63:0]   nb;

  mgd_pkg::alu_ctl_t alu_ctl;
  mgd_pkg::vel_t     alu_res;

  assign eff_w = ({4'd0, grid_width} > 11'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width;
  assign eff_h = ({4'd0, grid_height} > 11'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height;
  assign cell_total = eff_w * eff_h;
  assign idx_ok   = {2'd0, cell_index} < cell_total;
  assign idx_wide = (AW+12)'(cell_index);
  assign idx_addr = idx_wide[AW-1:0];
  assign w_a      = AW'(eff_w);

  assign busy = (state != ST_IDLE);

  // Read address: neighbours outside the grid fall back to the cell itself.
  always_comb begin
    case (state)
      ST_Z0:   raddr = pos_c;
      ST_R0:   raddr = pos_c;
      ST_R1:   raddr = (pos_x != 7'd0) ? pos_c - AW'(1) : pos_c;
      ST_R2:   raddr = (pos_x + 7'd1 < eff_w) ? pos_c + AW'(1) : pos_c;
      ST_R3:   raddr = (pos_y != 7'd0) ? pos_c - w_a : pos_c;
      ST_R4:   raddr = (pos_y + 7'd1 < eff_h) ? pos_c + w_a : pos_c;
      default: raddr = idx_addr;
    endcase
  end

  assign wr_load = (state == ST_IDLE) && start && (req_type == mgd_pkg::REQ_LOAD) && idx_ok;
  assign wr_run  = (state == ST_WR);
  assign wr_zero = (state == ST_Z1) && !mask_rd;
  assign waddr   = (wr_run || wr_zero) ? pos_c : idx_addr;
  assign wdata   = wr_run ? (cen_act ? {alu_res, res_x} : 64'd0) :
                   (wr_zero ? 64'd0 : {load_vel_y, load_vel_x});
  assign we_a    = ((wr_load || wr_zero) && !cur) || (wr_run && cur);
  assign we_b    = ((wr_load || wr_zero) && cur) || (wr_run && !cur);
  assign rdata   = cur ? rdata_b : rdata_a;
  assign nb      = mask_rd ? rdata : 64'd0;

  assign alu_ctl.mul_en = (state == ST_MX) || (state == ST_MY);
  assign alu_ctl.sel_y  = (state == ST_MY);

  mgd_ram #(.WIDTH(64), .DEPTH(CELLS)) u_store_a (
    .clk(clk), .we(we_a), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_a)
  );

  mgd_ram #(.WIDTH(64), .DEPTH(CELLS)) u_store_b (
    .clk(clk), .we(we_b), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_b)
  );

  mgd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mask (
    .clk(clk), .we(wr_load), .waddr(idx_addr), .wdata(load_active), .raddr(raddr),
    .rdata(mask_rd)
  );

  mgd_alu u_alu (
    .clk(clk), .ctl(alu_ctl), .rate(diffusion_rate), .acc_x(acc_x), .acc_y(acc_y),
    .cen_x(cen_x), .cen_y(cen_y), .result(alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= 7'd64;
      grid_height    <= 7'd64;
      step_count     <= 16'd0;
      diffusion_rate <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mgd_pkg::REG_WIDTH:  grid_width <= cfg_data[6:0];
        mgd_pkg::REG_HEIGHT: grid_height <= cfg_data[6:0];
        mgd_pkg::REG_STEPS:  step_count <= cfg_data;
        mgd_pkg::REG_RATE:   diffusion_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        in_range <= idx_ok;
      end
      ST_R1: begin
        cen_act <= mask_rd;
        cen_x   <= nb[31:0];
        cen_y   <= nb[63:32];
        acc_x   <= -((mgd_pkg::ACC_W)'(signed'(nb[31:0])) <<< 2);
        acc_y   <= -((mgd_pkg::ACC_W)'(signed'(nb[63:32])) <<< 2);
      end
      ST_R2, ST_R3, ST_R4, ST_R5: begin
        acc_x <= acc_x + (mgd_pkg::ACC_W)'(signed'(nb[31:0]));
        acc_y <= acc_y + (mgd_pkg::ACC_W)'(signed'(nb[63:32]));
      end
      ST_MY: begin
        res_x <= alu_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur        <= 1'b0;
      done       <= 1'b0;
      resp_kind  <= mgd_pkg::RESP_RUN;
      out_vel_x  <= 32'd0;
      out_vel_y  <= 32'd0;
      pos_x      <= 7'd0;
      pos_y      <= 7'd0;
      pos_c      <= '0;
      steps_left <= 16'd0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (req_type == mgd_pkg::REQ_READ) begin
              state <= ST_RDOUT;
            end else if (req_type == mgd_pkg::REQ_RUN) begin
              pos_x      <= 7'd0;
              pos_y      <= 7'd0;
              pos_c      <= '0;
              steps_left <= step_count;
              if (eff_w == 7'd0 || eff_h == 7'd0 || step_count == 16'd0 ||
                  diffusion_rate == 16'd0) begin
                state <= ST_DONE;
              end else begin
                state <= ST_Z0;
              end
            end
          end
        end
        ST_RDOUT: begin
          done      <= 1'b1;
          resp_kind <= mgd_pkg::RESP_READ;
          out_vel_x <= in_range ? rdata[31:0] : 32'd0;
          out_vel_y <= in_range ? rdata[63:32] : 32'd0;
          state     <= ST_IDLE;
        end
        ST_DONE: begin
          done      <= 1'b1;
          resp_kind <= mgd_pkg::RESP_RUN;
          out_vel_x <= 32'd0;
          out_vel_y <= 32'd0;
          state     <= ST_IDLE;
        end
        ST_Z0: state <= ST_Z1;
        ST_Z1: begin
          state <= ST_Z0;
          if (pos_x + 7'd1 < eff_w) begin
            pos_x <= pos_x + 7'd1;
            pos_c <= pos_c + AW'(1);
          end else begin
            pos_x <= 7'd0;
            if (pos_y + 7'd1 < eff_h) begin
              pos_y <= pos_y + 7'd1;
              pos_c <= pos_c + AW'(1);
            end else begin
              pos_y <= 7'd0;
              pos_c <= '0;
              state <= ST_R0;
            end
          end
        end
        ST_R0: state <= ST_R1;
        ST_R1: state <= ST_R2;
        ST_R2: state <= ST_R3;
        ST_R3: state <= ST_R4;
        ST_R4: state <= ST_R5;
        ST_R5: state <= ST_MX;
        ST_MX: state <= ST_MY;
        ST_MY: state <= ST_WR;
        ST_WR: begin
          state <= ST_R0;
          if (pos_x + 7'd1 < eff_w) begin
            pos_x <= pos_x + 7'd1;
            pos_c <= pos_c + AW'(1);
          end else begin
            pos_x <= 7'd0;
            if (pos_y + 7'd1 < eff_h) begin
              pos_y <= pos_y + 7'd1;
              pos_c <= pos_c + AW'(1);
            end else begin
              pos_y <= 7'd0;
              pos_c <= '0;
              cur   <= ~cur;
              if (steps_left == 16'd1) begin
                state <= ST_DONE;
              end else begin
                steps_left <= steps_left - 16'd1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
